// ===== rtl/lru_key_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// lru_key_tracker_defines.svh
// Assertion macros used by the LRU key tracker top level.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TRACKER_DEFINES_SVH
`define LRU_KEY_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LKT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LKT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lkt_pkg.sv =====
// ----------------------------------------------------------------------------
// lkt_pkg
// Sizes, types and state codes of the LRU key tracker.
// ----------------------------------------------------------------------------
package lkt_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 32;
    localparam int CAP_W    = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // width that holds any position number and any capacity value
    localparam int POS_W = $clog2(ENTRIES) + 1;
    localparam int CMP_W = (POS_W > CAP_W) ? POS_W : CAP_W;

    typedef logic [KEY_BITS-1:0] key_t;

    // per-cell control
    typedef struct packed {
        logic cmp;    // latch compare result
        logic upd;    // commit the stack update
        logic shift;  // take neighbor's entry
        logic keep;   // position is below capacity
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

endpackage

// ===== rtl/lkt_cell.sv =====
// ----------------------------------------------------------------------------
// lkt_cell
// One recency stack position: key, valid bit, match flag, shift from neighbor.
// ----------------------------------------------------------------------------
module lkt_cell
    import lkt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  key_t      look_key,
    input  key_t      prev_key,
    input  logic      prev_valid,
    output key_t      cell_key,
    output logic      cell_valid,
    output logic      match
);

    key_t key_reg;
    logic valid_reg;
    logic match_reg;

    // compare flag, taken in the compare cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            match_reg <= valid_reg && (key_reg == look_key);
        end
    end

    // valid bit: shift or hold, then trim to capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.upd)
        begin
            valid_reg <= (ctl.shift ? prev_valid : valid_reg) && ctl.keep;
        end
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.upd && ctl.shift)
        begin
            key_reg <= prev_key;
        end
    end

    assign cell_key   = key_reg;
    assign cell_valid = valid_reg;
    assign match      = match_reg;

endmodule

// ===== rtl/lkt_recency.sv =====
// ----------------------------------------------------------------------------
// lkt_recency
// Turns the match row into per-cell shift and keep controls and the hit flag.
// ----------------------------------------------------------------------------
module lkt_recency
    import lkt_pkg::*;
(
    input  logic [ENTRIES-1:0]   match,
    input  logic [CAP_W-1:0]     capacity,
    input  logic                 do_cmp,
    input  logic                 do_upd,
    output cell_ctl_t            ctl [ENTRIES],
    output logic                 hit
);

    logic [CMP_W-1:0] cap_ext;

    assign cap_ext = CMP_W'(capacity);
    assign hit     = |match;

    // a cell shifts when no lower position matched
    always_comb
    begin
        logic [ENTRIES-1:0] low_mask;
        for (int i = 0; i < ENTRIES; i++)
        begin
            low_mask        = (ENTRIES'(1) << i) - ENTRIES'(1);
            ctl[i].cmp      = do_cmp;
            ctl[i].upd      = do_upd;
            ctl[i].shift    = ~|(match & low_mask);
            ctl[i].keep     = CMP_W'(i) < cap_ext;
        end
    end

endmodule

// ===== rtl/lru_key_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_key_tracker
// Fully associative LRU recency stack built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  key     | key_valid, key_stall, key      | in,  stall driven here
//  hit     | hit_valid, hit_stall, hit      | out, stall driven by sink
//  cfg     | cfg_valid, cfg_ready, cfg_data | in,  capacity write
//
//  An access goes through accept, compare in every cell, then shift.
//  The compare row is registered, so the update cycle sees only the
//  prefix OR of matches and the neighbor mux of each cell.
//  Reset clears all valid bits at once and sets capacity to 64.
//  A stalled result holds the update cycle until the output register frees.
// ----------------------------------------------------------------------------
`include "lru_key_tracker_defines.svh"

module lru_key_tracker
    import lkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_valid,
    output logic             key_stall,
    input  logic [KEY_BITS-1:0] key,
    output logic             hit_valid,
    input  logic             hit_stall,
    output logic             hit,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    state_t           state_reg, state_next;
    logic [CAP_W-1:0] capacity_reg;
    key_t             key_reg;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg;
    logic             do_cmp, do_upd, key_take, row_hit;

    key_t             key_arr   [ENTRIES];
    logic             valid_arr [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    cell_ctl_t        ctl       [ENTRIES];

    // capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // input transfer
    assign key_stall = (state_reg != ST_IDLE);
    assign key_take  = key_valid && !key_stall;

    always_ff @(posedge clk)
    begin
        if (key_take)
        begin
            key_reg <= key;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && hit_stall;
        do_cmp         = 1'b0;
        do_upd         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_take)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                do_cmp     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!out_valid_reg || !hit_stall)
                begin
                    do_upd         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (do_upd)
        begin
            hit_reg <= row_hit;
        end
    end

    assign hit_valid = out_valid_reg;
    assign hit       = hit_reg;

    // shift and trim controls
    lkt_recency u_recency (
        .match    (match_vec),
        .capacity (capacity_reg),
        .do_cmp   (do_cmp),
        .do_upd   (do_upd),
        .ctl      (ctl),
        .hit      (row_hit)
    );

    // row of cells; cell 0 takes the new key
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        key_t prev_k;
        logic prev_v;
        if (g == 0)
        begin : g_head
            assign prev_k = key_reg;
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_k = key_arr[g-1];
            assign prev_v = valid_arr[g-1];
        end
        lkt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[g]),
            .look_key   (key_reg),
            .prev_key   (prev_k),
            .prev_valid (prev_v),
            .cell_key   (key_arr[g]),
            .cell_valid (valid_arr[g]),
            .match      (match_vec[g])
        );
    end

    // checks
    `LKT_ASSERT_NXT(a_take_to_cmp, key_take, state_reg == ST_CMP, "accept did not start compare")
    `LKT_ASSERT_IMP(a_unique_match, state_reg == ST_UPD, $onehot0(match_vec), "key held twice")
    `LKT_ASSERT_NXT(a_head_loaded, do_upd && (capacity_reg != '0),
        valid_arr[0] && (key_arr[0] == key_reg), "new key not at head")
    `LKT_ASSERT_NXT(a_result_out, do_upd, hit_valid, "update gave no result")

endmodule
